// ===== hw/rtl/matrix_keypad_scan_debounce_defines.svh =====
// Assertion macros for the keypad scanner, compiled out under SYNTHESIS.
`ifndef MATRIX_KEYPAD_SCAN_DEBOUNCE_DEFINES_SVH
`define MATRIX_KEYPAD_SCAN_DEBOUNCE_DEFINES_SVH

`ifndef SYNTHESIS

// Condition holds on every clock edge out of reset.
`define MKS_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define MKS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Antecedent implies consequent at the same edge.
`define MKS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`else

`define MKS_ASSERT_ALWAYS(lbl, cond, msg)
`define MKS_ASSERT_NEXT(lbl, ante, cons, msg)
`define MKS_ASSERT_SAME(lbl, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/mks_pkg.sv =====
// Shared types, constants and helper functions for the keypad scanner.
package mks_pkg;

	localparam int unsigned ROW_W  = 4;
	localparam int unsigned COL_W  = 2;
	localparam int unsigned CODE_W = 4;
	localparam int unsigned CNT_W  = 8;
	localparam int unsigned HROW_W = 3;
	localparam int unsigned CFG_W  = 8;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_RECHECK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 2'd1;

	localparam logic [CNT_W-1:0] RECHECK_RST = 8'd4;
	localparam logic [CNT_W-1:0] RELEASE_RST = 8'd6;

	localparam logic [CODE_W-1:0] KEY_LEFT   = 4'd10;
	localparam logic [CODE_W-1:0] KEY_RIGHT  = 4'd11;
	localparam logic [CODE_W-1:0] KEY_ENTER  = 4'd12;
	localparam logic [CODE_W-1:0] KEY_ESCAPE = 4'd13;
	localparam logic [CODE_W-1:0] KEY_DOWN   = 4'd14;
	localparam logic [CODE_W-1:0] KEY_UP     = 4'd15;

	localparam logic [HROW_W-1:0] NO_ROW = 3'd0;

	typedef logic [ROW_W-1:0]  row_lines_t;
	typedef logic [COL_W-1:0]  col_idx_t;
	typedef logic [CODE_W-1:0] key_code_t;
	typedef logic [CNT_W-1:0]  count_t;
	typedef logic [HROW_W-1:0] row_num_t;

	// Lowest numbered active row wins; 0 when no row is active.
	function automatic row_num_t encode_row(input row_lines_t lines);
		row_num_t r;
		if (lines[0])
			r = 3'd1;
		else if (lines[1])
			r = 3'd2;
		else if (lines[2])
			r = 3'd3;
		else if (lines[3])
			r = 3'd4;
		else
			r = NO_ROW;
		return r;
	endfunction

	// Key map by column and row (row_sel 0 is row 1).
	function automatic key_code_t key_map(input col_idx_t col, input logic [1:0] row_sel);
		key_code_t k;
		case ({col, row_sel})
			4'b00_00: k = KEY_LEFT;
			4'b00_01: k = 4'd7;
			4'b00_10: k = 4'd4;
			4'b00_11: k = 4'd1;
			4'b01_00: k = 4'd0;
			4'b01_01: k = 4'd8;
			4'b01_10: k = 4'd5;
			4'b01_11: k = 4'd2;
			4'b10_00: k = KEY_RIGHT;
			4'b10_01: k = 4'd9;
			4'b10_10: k = 4'd6;
			4'b10_11: k = 4'd3;
			4'b11_00: k = KEY_ENTER;
			4'b11_01: k = KEY_ESCAPE;
			4'b11_10: k = KEY_DOWN;
			4'b11_11: k = KEY_UP;
			default:  k = 4'd0;
		endcase
		return k;
	endfunction

endpackage

// ===== hw/rtl/mks_channels.sv =====
// Valid/ready channel interfaces for row samples and key results.
interface mks_row_if import mks_pkg::*; ();
	logic       valid;
	logic       ready;
	row_lines_t row_lines;

	modport source (output valid, output row_lines, input ready);
	modport sink   (input valid, input row_lines, output ready);
endinterface

interface mks_key_if import mks_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       key_valid;
	key_code_t  key_code;
	row_lines_t column_drive;

	modport source (output valid, output key_valid, output key_code, output column_drive,
		input ready);
	modport sink   (input valid, input key_valid, input key_code, input column_drive,
		output ready);
endinterface

// ===== hw/rtl/matrix_keypad_scan_debounce.sv =====
// Top level: 4x4 keypad scan, debounce and key release detection.
// The result request appears in the cycle after its row request is accepted.
// Throughput: one request per cycle while the key channel is ready; the result
// register lets a new request in while the previous result is being taken.
// Reset: column 1, no press tracked, counts at 4 and 6, no result pending.
`include "matrix_keypad_scan_debounce_defines.svh"

module matrix_keypad_scan_debounce import mks_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	mks_row_if.sink              row_chan,
	mks_key_if.source            key_chan
);

	count_t    recheck_q, release_q;
	col_idx_t  col_q, col_nxt;
	count_t    cnt_q, cnt_nxt, cnt_inc;
	row_num_t  held_q, held_nxt;
	key_code_t pend_q, pend_nxt;

	logic      res_valid;
	key_code_t res_code;
	row_num_t  row;
	logic      accept;

	logic       out_valid_q;
	logic       out_kv_q;
	key_code_t  out_code_q;
	row_lines_t out_col_q;

	assign row      = encode_row(row_chan.row_lines);
	assign accept   = row_chan.valid && row_chan.ready;
	assign cnt_inc  = cnt_q + 8'd1;

	assign row_chan.ready = !out_valid_q || key_chan.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recheck_q <= RECHECK_RST;
			release_q <= RELEASE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RECHECK: recheck_q <= cfg_data;
				REG_RELEASE: release_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		col_nxt   = col_q;
		cnt_nxt   = cnt_q;
		held_nxt  = held_q;
		pend_nxt  = pend_q;
		res_valid = 1'b0;
		res_code  = 4'd0;
		if (cnt_q == 8'd0) begin
			if (row == NO_ROW) begin
				col_nxt = col_q + 2'd1;
			end else begin
				pend_nxt = key_map(col_q, 2'(row - 3'd1));
				cnt_nxt  = 8'd1;
				held_nxt = row;
			end
		end else if (cnt_q < release_q) begin
			cnt_nxt = cnt_inc;
			// recheck: a different row drops the press
			if (cnt_inc == recheck_q && held_q != row) begin
				cnt_nxt  = 8'd0;
				held_nxt = NO_ROW;
				pend_nxt = 4'd0;
			end
		end else if (row == NO_ROW) begin
			res_valid = 1'b1;
			res_code  = pend_q;
			cnt_nxt   = 8'd0;
			held_nxt  = NO_ROW;
			pend_nxt  = 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			cnt_q  <= '0;
			held_q <= NO_ROW;
			pend_q <= '0;
		end else if (accept) begin
			col_q  <= col_nxt;
			cnt_q  <= cnt_nxt;
			held_q <= held_nxt;
			pend_q <= pend_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (accept)
			out_valid_q <= 1'b1;
		else if (key_chan.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_kv_q   <= res_valid;
			out_code_q <= res_code;
			out_col_q  <= 4'b0001 << col_nxt;
		end
	end

	assign key_chan.valid        = out_valid_q;
	assign key_chan.key_valid    = out_kv_q;
	assign key_chan.key_code     = out_code_q;
	assign key_chan.column_drive = out_col_q;

	`MKS_ASSERT_SAME(a_held_row_set, cnt_q != 8'd0, held_q != NO_ROW, "press without held row")
	`MKS_ASSERT_SAME(a_col_onehot, out_valid_q, $onehot(out_col_q), "column drive not one-hot")
	`MKS_ASSERT_NEXT(a_release_clears, accept && res_valid, cnt_q == 8'd0, "release left count set")
	`MKS_ASSERT_NEXT(a_col_hold, cnt_q != 8'd0, col_q == $past(col_q), "column moved during press")

endmodule
